### hw/rtl/rch_pkg.sv
// ----------------------------------------------------------------------------
// rch_pkg: shared types and constants of the color histogram block
// Widths, register indexes, the queue entry and the queue head structs.
// ----------------------------------------------------------------------------
package rch_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int LEVEL_BITS = 3;
  localparam int CH_W       = 8;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int BIN_W      = 3 * LEVEL_BITS;
  localparam int NBINS      = 1 << BIN_W;
  localparam int CNT_W      = 21;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_DIM * MAX_DIM);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 2'd3;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;
  localparam logic [DIM_W-1:0] RST_WINDOW_WIDTH  = 11'd40;
  localparam logic [DIM_W-1:0] RST_WINDOW_HEIGHT = 11'd120;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // one classified pixel
  typedef struct packed {
    logic             count;
    logic             frame_end;
    logic             win_ok;
    logic [BIN_W-1:0] bin;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

endpackage

### hw/rtl/rch_pix_if.sv
// ----------------------------------------------------------------------------
// rch_pix_if: pixel request channel
// Valid/ready channel that carries one raster pixel.
// ----------------------------------------------------------------------------
interface rch_pix_if;
  logic                        valid;
  logic                        ready;
  logic [rch_pkg::COORD_W-1:0] pixel_row;
  logic [rch_pkg::COORD_W-1:0] pixel_col;
  logic [rch_pkg::CH_W-1:0]    blue;
  logic [rch_pkg::CH_W-1:0]    green;
  logic [rch_pkg::CH_W-1:0]    red;
  logic                        frame_end;

  modport source (output valid, pixel_row, pixel_col, blue, green, red, frame_end,
                  input ready);
  modport sink (input valid, pixel_row, pixel_col, blue, green, red, frame_end,
                output ready);
endinterface

### hw/rtl/rch_res_if.sv
// ----------------------------------------------------------------------------
// rch_res_if: result request channel
// Valid/ready channel that carries the top three bins of one frame.
// ----------------------------------------------------------------------------
interface rch_res_if;
  logic                      valid;
  logic                      ready;
  logic                      window_ok;
  logic [rch_pkg::BIN_W-1:0] first_bin;
  logic [rch_pkg::BIN_W-1:0] second_bin;
  logic [rch_pkg::BIN_W-1:0] third_bin;
  logic [rch_pkg::CNT_W-1:0] top_count;

  modport source (output valid, window_ok, first_bin, second_bin, third_bin, top_count,
                  input ready);
  modport sink (input valid, window_ok, first_bin, second_bin, third_bin, top_count,
                output ready);
endinterface

### hw/rtl/rch_front.sv
// ----------------------------------------------------------------------------
// rch_front: pixel classifier
// Holds the configuration, checks the window and forms the bin index.
// ----------------------------------------------------------------------------
module rch_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rch_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rch_pkg::DIM_W-1:0]     cfg_wdata,
  rch_pix_if.sink                       pix,
  input  logic                          q_room,
  output logic                          push,
  output rch_pkg::entry_t               push_entry
);

  logic [rch_pkg::DIM_W-1:0]   img_w_r, img_h_r, win_w_r, win_h_r;
  logic [rch_pkg::COORD_W-1:0] cx, hw;
  logic [rch_pkg::DIM_W:0]     row_sum;
  logic [rch_pkg::DIM_W-1:0]   col_sum, col_lim;
  logic                        win_ok, row_in, col_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= rch_pkg::RST_IMAGE_WIDTH;
      img_h_r <= rch_pkg::RST_IMAGE_HEIGHT;
      win_w_r <= rch_pkg::RST_WINDOW_WIDTH;
      win_h_r <= rch_pkg::RST_WINDOW_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_idx)
        rch_pkg::REG_IMAGE_WIDTH:   img_w_r <= cfg_wdata;
        rch_pkg::REG_IMAGE_HEIGHT:  img_h_r <= cfg_wdata;
        rch_pkg::REG_WINDOW_WIDTH:  win_w_r <= cfg_wdata;
        rch_pkg::REG_WINDOW_HEIGHT: win_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    win_ok  = (win_w_r < img_w_r) && (win_h_r < img_h_r);
    cx      = img_w_r[rch_pkg::DIM_W-1:1];
    hw      = win_w_r[rch_pkg::DIM_W-1:1];
    row_sum = {2'b00, pix.pixel_row} + {1'b0, win_h_r};
    row_in  = (row_sum >= {1'b0, img_h_r}) && ({1'b0, pix.pixel_row} < img_h_r);
    col_sum = {1'b0, pix.pixel_col} + {1'b0, hw};
    col_lim = {1'b0, cx} + {1'b0, hw};
    col_in  = (col_sum >= {1'b0, cx}) && ({1'b0, pix.pixel_col} < col_lim);
  end

  assign pix.ready = q_room;
  assign push      = pix.valid && q_room;

  always_comb begin
    push_entry.count     = win_ok && row_in && col_in;
    push_entry.frame_end = pix.frame_end;
    push_entry.win_ok    = win_ok;
    push_entry.bin       = {pix.red[rch_pkg::CH_W-1 -: rch_pkg::LEVEL_BITS],
                            pix.green[rch_pkg::CH_W-1 -: rch_pkg::LEVEL_BITS],
                            pix.blue[rch_pkg::CH_W-1 -: rch_pkg::LEVEL_BITS]};
  end

endmodule

### hw/rtl/rch_queue.sv
// ----------------------------------------------------------------------------
// rch_queue: short queue between classifier and counter
// Small first-in first-out buffer of classified pixels.
// ----------------------------------------------------------------------------
module rch_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rch_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output rch_pkg::q_head_t head
);

  rch_pkg::entry_t              buf_r [rch_pkg::Q_DEPTH];
  logic [rch_pkg::Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [rch_pkg::Q_PTR_W:0]    fill_r, fill_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_entry;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_nxt;
    end
  end

  assign full       = (fill_r == (rch_pkg::Q_PTR_W+1)'(rch_pkg::Q_DEPTH));
  assign head.valid = (fill_r != '0);
  assign head.entry = buf_r[rd_ptr_r];

endmodule

### hw/rtl/rch_back.sv
// ----------------------------------------------------------------------------
// rch_back: bin counter, frame scan and result register
// Read-modify-write of the bin store, top three scan with clear, result out.
// ----------------------------------------------------------------------------
module rch_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rch_pkg::q_head_t head,
  output logic             pop,
  output logic             clearing,
  rch_res_if.source        res
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [rch_pkg::CNT_W-1:0] mem [rch_pkg::NBINS];
  logic [rch_pkg::CNT_W-1:0] rd_r;
  logic                      mem_we, mem_re;
  logic [rch_pkg::BIN_W-1:0] mem_wa, mem_ra;
  logic [rch_pkg::CNT_W-1:0] mem_wd;

  logic [rch_pkg::BIN_W-1:0] clr_addr_r;
  logic                      s1_v_r, s1_hit_r, hit_nxt;
  rch_pkg::entry_t           s1_r;
  logic [rch_pkg::CNT_W-1:0] wval_r, cur, inc;
  logic                      ok_r;

  logic [rch_pkg::BIN_W:0]   sc_addr_r;
  logic                      sc_v_r;
  logic [rch_pkg::BIN_W-1:0] sc_idx_r;
  logic [rch_pkg::BIN_W-1:0] bi0_r, bi1_r, bi2_r, bi0_nxt, bi1_nxt, bi2_nxt;
  logic [rch_pkg::CNT_W-1:0] bc0_r, bc1_r, bc2_r, bc0_nxt, bc1_nxt, bc2_nxt;

  logic                      out_v_r;
  logic                      load;
  logic                      out_ok_r;
  logic [rch_pkg::BIN_W-1:0] out_b0_r, out_b1_r, out_b2_r;
  logic [rch_pkg::CNT_W-1:0] out_cnt_r;

  // bin store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_r <= mem[mem_ra];
  end

  assign clearing = (state_r == ST_CLR);
  // hold the queue while the frame end pixel finishes its write
  assign pop      = (state_r == ST_RUN) && head.valid && !(s1_v_r && s1_r.frame_end);
  assign hit_nxt  = s1_v_r && s1_r.count && (s1_r.bin == head.entry.bin);
  assign cur      = s1_hit_r ? wval_r : rd_r;
  assign inc      = (cur < rch_pkg::COUNT_CAP) ? cur + 1'b1 : cur;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = s1_r.bin;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = head.entry.bin;
    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
      end
      ST_RUN: begin
        mem_we = s1_v_r && s1_r.count;
        mem_wd = inc;
        mem_re = pop;
      end
      ST_SCAN: begin
        // read and clear in the same cycle
        mem_we = !sc_addr_r[rch_pkg::BIN_W];
        mem_wa = sc_addr_r[rch_pkg::BIN_W-1:0];
        mem_re = !sc_addr_r[rch_pkg::BIN_W];
        mem_ra = sc_addr_r[rch_pkg::BIN_W-1:0];
      end
      default: ;
    endcase
  end

  // top three insertion, ties go to the later bin
  always_comb begin
    bi0_nxt = bi0_r; bi1_nxt = bi1_r; bi2_nxt = bi2_r;
    bc0_nxt = bc0_r; bc1_nxt = bc1_r; bc2_nxt = bc2_r;
    if (rd_r >= bc0_r) begin
      bi2_nxt = bi1_r;    bc2_nxt = bc1_r;
      bi1_nxt = bi0_r;    bc1_nxt = bc0_r;
      bi0_nxt = sc_idx_r; bc0_nxt = rd_r;
    end else if (rd_r >= bc1_r) begin
      bi2_nxt = bi1_r;    bc2_nxt = bc1_r;
      bi1_nxt = sc_idx_r; bc1_nxt = rd_r;
    end else if (rd_r >= bc2_r) begin
      bi2_nxt = sc_idx_r; bc2_nxt = rd_r;
    end
  end

  assign load = (state_r == ST_SEND) && (!out_v_r || res.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (clr_addr_r == '1) state_nxt = ST_RUN;
      ST_RUN:  if (s1_v_r && s1_r.frame_end) state_nxt = ST_SCAN;
      ST_SCAN: if (sc_addr_r[rch_pkg::BIN_W] && !sc_v_r) state_nxt = ST_SEND;
      ST_SEND: if (load) state_nxt = ST_RUN;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
      s1_v_r     <= 1'b0;
      sc_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_addr_r <= clr_addr_r + 1'b1;
      s1_v_r <= pop;
      sc_v_r <= (state_r == ST_SCAN) && !sc_addr_r[rch_pkg::BIN_W];
      if (load) begin
        out_v_r <= 1'b1;
      end else if (res.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r     <= head.entry;
      s1_hit_r <= hit_nxt;
    end
    if (state_r == ST_RUN && mem_we) wval_r <= mem_wd;
    if (state_r == ST_RUN && s1_v_r && s1_r.frame_end) begin
      ok_r      <= s1_r.win_ok;
      sc_addr_r <= '0;
      bi0_r <= '0; bi1_r <= '0; bi2_r <= '0;
      bc0_r <= '0; bc1_r <= '0; bc2_r <= '0;
    end
    if (state_r == ST_SCAN) begin
      if (!sc_addr_r[rch_pkg::BIN_W]) sc_addr_r <= sc_addr_r + 1'b1;
      sc_idx_r <= sc_addr_r[rch_pkg::BIN_W-1:0];
      if (sc_v_r) begin
        bi0_r <= bi0_nxt; bi1_r <= bi1_nxt; bi2_r <= bi2_nxt;
        bc0_r <= bc0_nxt; bc1_r <= bc1_nxt; bc2_r <= bc2_nxt;
      end
    end
    if (load) begin
      out_ok_r  <= ok_r;
      out_b0_r  <= ok_r ? bi0_r : '0;
      out_b1_r  <= ok_r ? bi1_r : '0;
      out_b2_r  <= ok_r ? bi2_r : '0;
      out_cnt_r <= ok_r ? bc0_r : '0;
    end
  end

  assign res.valid      = out_v_r;
  assign res.window_ok  = out_ok_r;
  assign res.first_bin  = out_b0_r;
  assign res.second_bin = out_b1_r;
  assign res.third_bin  = out_b2_r;
  assign res.top_count  = out_cnt_r;

endmodule

### hw/rtl/roi_color_histogram_top_bins_unit.sv
// ----------------------------------------------------------------------------
// roi_color_histogram_top_bins_unit: windowed color histogram, top three bins
// Counts quantized pixels of a bottom-centered window, ranks bins per frame.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake          | payload
//  in_pix    | in  | valid/ready        | pixel_row, pixel_col, blue, green, red,
//            |     |                    | frame_end
//  out_res   | out | valid/ready        | window_ok, first_bin, second_bin,
//            |     |                    | third_bin, top_count
//  cfg_*     | in  | cfg_we, no wait    | cfg_idx, cfg_wdata
//
//  One pixel per cycle while the queue has room; a counted pixel goes through
//  the store's read port and its write port in the next cycle, with forwarding
//  for back-to-back bins. Frame end adds a scan of all 512 bins of the store
//  (read and clear); pixels queue up to four deep meanwhile, then in_pix stalls.
//  After reset a clearing pass over all 512 bins runs with in_pix.ready low.
//  A stalled result waits in the output register; the next frame's report
//  holds behind it after its scan, and the queue fills meanwhile.
module roi_color_histogram_top_bins_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rch_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rch_pkg::DIM_W-1:0]     cfg_wdata,
  rch_pix_if.sink                       in_pix,
  rch_res_if.source                     out_res
);

  logic             q_full, q_room, push, pop, clearing;
  rch_pkg::entry_t  push_entry;
  rch_pkg::q_head_t head;

  assign q_room = !q_full && !clearing;

  rch_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .pix        (in_pix),
    .q_room     (q_room),
    .push       (push),
    .push_entry (push_entry)
  );

  rch_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  rch_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .res      (out_res)
  );

endmodule

### tb/sv/roi_color_histogram_top_bins_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_color_histogram_top_bins_unit_test: self-checking bench of the histogram
// Drives pixels and window settings and keeps its own tally of the 512 bins.
// It ranks the bins on every frame end and compares each top-three report
// field by field.
// ----------------------------------------------------------------------------
module roi_color_histogram_top_bins_unit_test;
  import rch_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 3000;
  localparam int IDLE_PCT      = 9;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 225;
  localparam int DIRECTED_ROWS = 22;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    red;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic             window_ok;
    logic [BIN_W-1:0] first_bin;
    logic [BIN_W-1:0] second_bin;
    logic [BIN_W-1:0] third_bin;
    logic [CNT_W-1:0] top_count;
  } top_bins_t;

  typedef struct packed {
    logic             new_window;
    logic [DIM_W-1:0] img_w;
    logic [DIM_W-1:0] img_h;
    logic [DIM_W-1:0] win_w;
    logic [DIM_W-1:0] win_h;
    pixel_t           pix;
    logic             typed;
    top_bins_t        want;
  } dir_row_t;

  localparam top_bins_t EMPTY_TOP = '{1'b1, 9'd511, 9'd510, 9'd509, 21'd0};
  localparam top_bins_t BAD_TOP   = '{1'b0, 9'd0, 9'd0, 9'd0, 21'd0};
  localparam top_bins_t NO_TOP    = '0;

  // reset window: rows 360..479, columns 300..339
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, 11'd640, 11'd480, 11'd40, 11'd120,
      '{10'd0, 10'd0, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, EMPTY_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd479, 10'd300, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd360, 10'd339, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd360, 10'd340, 8'hff, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd359, 10'd300, 8'h00, 8'hff, 8'h00, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd479, 10'd299, 8'h00, 8'h00, 8'hff, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd1023, 10'd1023, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd479, 10'd300, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd400, 10'd320, 8'he0, 8'h00, 8'h00, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd400, 10'd320, 8'h00, 8'he0, 8'h00, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd400, 10'd320, 8'h00, 8'h00, 8'he0, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd400, 10'd320, 8'h1f, 8'h1f, 8'h1f, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd420, 10'd310, 8'hff, 8'h00, 8'h00, 1'b1}, 1'b0, NO_TOP},
    // window as wide as the image, then as high as the image
    '{1'b1, 11'd640, 11'd480, 11'd640, 11'd0,
      '{10'd479, 10'd320, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, BAD_TOP},
    '{1'b1, 11'd640, 11'd480, 11'd0, 11'd480,
      '{10'd479, 10'd320, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, BAD_TOP},
    '{1'b1, 11'd0, 11'd0, 11'd0, 11'd0,
      '{10'd0, 10'd0, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, BAD_TOP},
    // zero-height window on a one-pixel image counts nothing
    '{1'b1, 11'd1, 11'd1, 11'd0, 11'd0,
      '{10'd0, 10'd0, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, EMPTY_TOP},
    '{1'b1, 11'd2047, 11'd2047, 11'd2046, 11'd2046,
      '{10'd1023, 10'd1023, 8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd0, 10'd0, 8'hff, 8'h00, 8'hff, 1'b0}, 1'b0, NO_TOP},
    '{1'b0, '0, '0, '0, '0, '{10'd1023, 10'd0, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, NO_TOP},
    '{1'b1, 11'd1024, 11'd1024, 11'd1023, 11'd1023,
      '{10'd1, 10'd512, 8'h80, 8'h80, 8'h80, 1'b1}, 1'b0, NO_TOP},
    '{1'b1, 11'd640, 11'd480, 11'd40, 11'd120,
      '{10'd479, 10'd339, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b0, NO_TOP}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIM_W-1:0]     cfg_wdata;

  rch_pix_if in_pix ();
  rch_res_if out_res ();

  roi_color_histogram_top_bins_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .out_res   (out_res)
  );

  // bench copy of the registers and of the bin store
  logic [DIM_W-1:0] img_w, img_h, win_w, win_h;
  logic [CNT_W-1:0] bin_tally [NBINS];
  top_bins_t        top_bins_due [$];

  int errors   = 0;
  int cycles   = 0;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("simulation failed");
      $finish;
    end
  end

  // count one pixel; on frame end rank the bins (or report a bad window), queue the report, clear
  task automatic tally_pixel(input pixel_t p);
    int               cx, hw;
    bit               ok;
    logic [BIN_W-1:0] bin;
    logic [CNT_W-1:0] c;
    logic [BIN_W-1:0] bi [3];
    logic [CNT_W-1:0] bc [3];
    ok = (win_w < img_w) && (win_h < img_h);
    cx = int'(img_w) / 2;
    hw = int'(win_w) / 2;
    bin = {p.red[CH_W-1 -: LEVEL_BITS], p.green[CH_W-1 -: LEVEL_BITS],
           p.blue[CH_W-1 -: LEVEL_BITS]};
    if (ok && int'(p.pixel_row) + int'(win_h) >= int'(img_h) && p.pixel_row < img_h &&
        int'(p.pixel_col) + hw >= cx && int'(p.pixel_col) < cx + hw) begin
      if (bin_tally[bin] < COUNT_CAP) bin_tally[bin] = bin_tally[bin] + 1'b1;
    end
    if (!p.frame_end) return;
    if (!ok) begin
      top_bins_due.push_back(BAD_TOP);
    end else begin
      bi = '{'0, '0, '0};
      bc = '{'0, '0, '0};
      // ties move up, so the higher index wins
      for (int i = 0; i < NBINS; i++) begin
        c = bin_tally[i];
        if (c >= bc[0]) begin
          bi[2] = bi[1]; bc[2] = bc[1];
          bi[1] = bi[0]; bc[1] = bc[0];
          bi[0] = BIN_W'(i); bc[0] = c;
        end else if (c >= bc[1]) begin
          bi[2] = bi[1]; bc[2] = bc[1];
          bi[1] = BIN_W'(i); bc[1] = c;
        end else if (c >= bc[2]) begin
          bi[2] = BIN_W'(i); bc[2] = c;
        end
      end
      top_bins_due.push_back('{1'b1, bi[0], bi[1], bi[2], bc[0]});
    end
    for (int i = 0; i < NBINS; i++) bin_tally[i] = '0;
  endtask

  task automatic send_pixel(input pixel_t p);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_pix.valid <= 1'b0;
    end
    @(negedge clk);
    in_pix.valid     <= 1'b1;
    in_pix.pixel_row <= p.pixel_row;
    in_pix.pixel_col <= p.pixel_col;
    in_pix.blue      <= p.blue;
    in_pix.green     <= p.green;
    in_pix.red       <= p.red;
    in_pix.frame_end <= p.frame_end;
    do @(posedge clk); while (!in_pix.ready);
    tally_pixel(p);
  endtask

  // wait until the block is idle, then write all four registers
  task automatic set_window(input logic [DIM_W-1:0] iw, ih, ww, wh);
    @(negedge clk);
    in_pix.valid <= 1'b0;
    while (top_bins_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_IMAGE_WIDTH;
    cfg_wdata <= iw;
    @(negedge clk);
    cfg_idx   <= REG_IMAGE_HEIGHT;
    cfg_wdata <= ih;
    @(negedge clk);
    cfg_idx   <= REG_WINDOW_WIDTH;
    cfg_wdata <= ww;
    @(negedge clk);
    cfg_idx   <= REG_WINDOW_HEIGHT;
    cfg_wdata <= wh;
    @(negedge clk);
    cfg_we <= 1'b0;
    img_w = iw;
    img_h = ih;
    win_w = ww;
    win_h = wh;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_res.ready <= 1'b1;
      end else begin
        out_res.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      if (top_bins_due.size() == 0) begin
        errors++;
        $display("%0t: result with no frame end pending", $time);
      end else begin
        check_field("window_ok", top_bins_due[0].window_ok, out_res.window_ok);
        check_field("first_bin", top_bins_due[0].first_bin, out_res.first_bin);
        check_field("second_bin", top_bins_due[0].second_bin, out_res.second_bin);
        check_field("third_bin", top_bins_due[0].third_bin, out_res.third_bin);
        check_field("top_count", top_bins_due[0].top_count, out_res.top_count);
        void'(top_bins_due.pop_front());
      end
    end
  end

  initial begin
    dir_row_t         row;
    pixel_t           px;
    logic [DIM_W-1:0] iw, ih, ww, wh;
    logic [23:0]      palette [4];
    bit               refresh;
    bit               aimed;
    int               fe_odds, lo_r, hi_r, lo_c, hi_c;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_IMAGE_WIDTH;
    cfg_wdata        = '0;
    in_pix.valid     = 1'b0;
    in_pix.pixel_row = '0;
    in_pix.pixel_col = '0;
    in_pix.blue      = '0;
    in_pix.green     = '0;
    in_pix.red       = '0;
    in_pix.frame_end = 1'b0;
    img_w = RST_IMAGE_WIDTH;
    img_h = RST_IMAGE_HEIGHT;
    win_w = RST_WINDOW_WIDTH;
    win_h = RST_WINDOW_HEIGHT;
    for (int i = 0; i < NBINS; i++) bin_tally[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.new_window) set_window(row.img_w, row.img_h, row.win_w, row.win_h);
      send_pixel(row.pix);
      if (row.typed) top_bins_due[top_bins_due.size() - 1] = row.want;
    end

    refresh = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          iw = RST_IMAGE_WIDTH; ih = RST_IMAGE_HEIGHT;
          ww = RST_WINDOW_WIDTH; wh = RST_WINDOW_HEIGHT;
        end
        1: begin
          iw = 11'd1024; ih = 11'd1024; ww = 11'd1023; wh = 11'd1023;
        end
        2: begin
          iw = DIM_W'($urandom_range(32, 1));
          ih = DIM_W'($urandom_range(32, 1));
          ww = DIM_W'($urandom_range(iw - 1, 0));
          wh = DIM_W'($urandom_range(ih - 1, 0));
        end
        3: begin
          // window at least as wide as the image
          iw = DIM_W'($urandom_range(1024, 1));
          ih = DIM_W'($urandom_range(1024, 1));
          ww = DIM_W'($urandom_range(2047, iw));
          wh = DIM_W'($urandom_range(2047, 0));
        end
        default: begin
          iw = DIM_W'($urandom_range(1024, 1));
          ih = DIM_W'($urandom_range(1024, 1));
          ww = DIM_W'($urandom_range(iw - 1, 0));
          wh = DIM_W'($urandom_range(ih - 1, 0));
        end
      endcase
      set_window(iw, ih, ww, wh);
      quiet   = (ph == 6);
      fe_odds = (ph == 5) ? 8 : 30;
      if (ph == 5) hold_req = 1'b1;

      lo_r = int'(img_h) - int'(win_h);
      hi_r = (int'(img_h) > 1024) ? 1023 : int'(img_h) - 1;
      lo_c = int'(img_w) / 2 - int'(win_w) / 2;
      hi_c = int'(img_w) / 2 + int'(win_w) / 2 - 1;
      if (hi_c > 1023) hi_c = 1023;
      aimed = (lo_r >= 0) && (lo_r <= hi_r) && (lo_c >= 0) && (lo_c <= hi_c);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (refresh) begin
          for (int k = 0; k < 4; k++) palette[k] = 24'($urandom);
        end
        // aim most pixels into the window so the bins fill up
        if (aimed && $urandom_range(99) < 75) begin
          px.pixel_row = COORD_W'($urandom_range(hi_r, lo_r));
          px.pixel_col = COORD_W'($urandom_range(hi_c, lo_c));
        end else begin
          px.pixel_row = COORD_W'($urandom);
          px.pixel_col = COORD_W'($urandom);
        end
        if ($urandom_range(99) < 60) begin
          {px.red, px.green, px.blue} = palette[$urandom_range(3)];
        end else begin
          {px.red, px.green, px.blue} = 24'($urandom);
        end
        px.frame_end = ($urandom_range(fe_odds - 1) == 0);
        refresh = px.frame_end;
        send_pixel(px);
      end
    end

    @(negedge clk);
    in_pix.valid <= 1'b0;
    while (top_bins_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
